[design/bdq_pkg.sv]
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // request codes; anything above REQ_STATUS acts as a status request
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_STATUS     = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [31:0] push_value;
  } bdq_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic        [4:0]  entry_count;
    logic        [1:0]  status;
  } bdq_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_back;   // push front: everything moves one cell back
    logic shift_front;  // pop front: everything moves one cell forward
    logic load_back;    // push back: first free cell takes the word
    logic drop_back;    // pop back: last occupied cell frees itself
  } bdq_ctl_t;

  // stored word -> 32-bit signed report
  function automatic logic [31:0] report(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] ext;
    ext = 64'($signed(w));
    return ext[31:0];
  endfunction

  // 32-bit input word -> stored width
  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [31:0] v);
    logic [63:0] ext;
    ext = 64'($signed(v));
    return ext[DATA_WIDTH-1:0];
  endfunction

endpackage

[design/bdq_cell.sv]
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdq_ctl_t              ctl,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic                  prev_occ,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  logic                  next_occ,
  output logic [DATA_WIDTH-1:0] data_r,
  output logic                  occ_r
);

  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (ctl.shift_back) begin
      data_nxt = prev_data;
      occ_nxt  = prev_occ;
    end else if (ctl.shift_front) begin
      data_nxt = next_data;
      occ_nxt  = next_occ;
    end else if (ctl.load_back && !occ_r && prev_occ) begin
      data_nxt = push_word;
      occ_nxt  = 1'b1;
    end else if (ctl.drop_back && occ_r && !next_occ) begin
      occ_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

[design/bounded_deque_unit.sv]
// Bounded deque of DEPTH signed words, built as a chain of shift cells.
// The result is registered: it is valid right after the edge that accepts the request.
// Throughput: one request per cycle while the result side keeps stall low.
// Reset (rst_n low, synchronous): queue empty, no result pending; cell data not cleared.
module bounded_deque_unit
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bdq_in_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output bdq_out_t out_rsp
);

  // Cell 0 always holds the front word. Occupancy forms a thermometer
  // code from cell 0, so the back word sits in the last occupied cell.
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_occ;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r;
  logic [31:0]           popped_r, popped_nxt;
  logic [1:0]            status_r, status_nxt;

  logic                  accept;
  logic                  empty, full;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] back_word;
  bdq_ctl_t              ctl;

  // a new request may enter as long as the result register is free or
  // being drained this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign empty     = !cell_occ[0];
  assign full      = cell_occ[DEPTH-1];
  assign push_word = to_word(in_req.push_value);

  // back word: one-hot select of the last occupied cell, zero when empty
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_occ[i] && (i == DEPTH - 1 || !cell_occ[(i + 1) % DEPTH])) begin
        back_word = back_word | cell_data[i];
      end
    end
  end

  // request decode
  always_comb begin
    ctl        = '0;
    cnt_nxt    = cnt_r;
    popped_nxt = '0;
    status_nxt = ST_DONE;
    if (accept) begin
      case (in_req.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.shift_back = (in_req.req_type == REQ_PUSH_FRONT);
            ctl.load_back  = (in_req.req_type == REQ_PUSH_BACK);
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.shift_front = (in_req.req_type == REQ_POP_FRONT);
            ctl.drop_back   = (in_req.req_type == REQ_POP_BACK);
            popped_nxt      = (in_req.req_type == REQ_POP_FRONT) ?
                              report(cell_data[0]) : report(back_word);
            cnt_nxt         = cnt_r - CNT_W'(1);
          end
        end
        default: begin
          // status only (REQ_STATUS and unused codes): nothing moves
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  // the chain: each cell exchanges data only with its two neighbors, plus the broadcast ctl and push word
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;
    logic                  prev_occ, next_occ;

    if (g == 0) begin : g_head
      assign prev_data = push_word;
      assign prev_occ  = 1'b1;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
      assign prev_occ  = cell_occ[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_data = '0;
      assign next_occ  = 1'b0;
    end else begin : g_body
      assign next_data = cell_data[g+1];
      assign next_occ  = cell_occ[g+1];
    end

    bdq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .push_word (push_word),
      .prev_data (prev_data),
      .prev_occ  (prev_occ),
      .next_data (next_data),
      .next_occ  (next_occ),
      .data_r    (cell_data[g]),
      .occ_r     (cell_occ[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
  end

  // Front and back come straight from the cells and count from cnt_r: they only change
  // on an accepted request, which cannot happen while the result is stalled.
  assign out_valid            = out_valid_r;
  assign out_rsp.popped_value = popped_r;
  assign out_rsp.front_value  = empty ? 32'd0 : report(cell_data[0]);
  assign out_rsp.back_value   = report(back_word);
  assign out_rsp.entry_count  = 5'(cnt_r);
  assign out_rsp.status       = status_r;

`ifndef NO_ASSERTIONS
  a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_occ) == int'(cnt_r))
    else $error("entry count disagrees with occupied cells");

  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_occ >> 1) & ~cell_occ) == '0)
    else $error("occupied cells not contiguous from the front");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_FULL |-> cnt_r == CNT_W'(DEPTH))
    else $error("full refusal with free cells");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> cnt_r == '0 && popped_r == '0)
    else $error("empty refusal on a non-empty queue");
`endif

endmodule
